@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file dqr_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define DQR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define DQR_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dqr_pkg.sv @@
// ----------------------------------------------------------------------------
// dqr_pkg
// types, constants and ring helpers for the bounded deque with reverse
// ----------------------------------------------------------------------------
`default_nettype none

package dqr_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 64;
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;

  // word packing
  localparam int IN_FUNC_LSB   = 0;
  localparam int IN_VALUE_LSB  = FUNC_W;
  localparam int IN_DATA_W     = ((FUNC_W + WORD_WIDTH + 7) / 8) * 8;

  localparam int OUT_FRONT_LSB  = 0;
  localparam int OUT_BACK_LSB   = WORD_WIDTH;
  localparam int OUT_COUNT_LSB  = 2 * WORD_WIDTH;
  localparam int OUT_EMPTY_LSB  = OUT_COUNT_LSB + CNT_W;
  localparam int OUT_STATUS_LSB = OUT_EMPTY_LSB + 1;
  localparam int OUT_FIELDS_W   = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  localparam logic [CNT_W:0] CAP_EXT  = (CNT_W + 1)'(CAPACITY);
  localparam cnt_t           CAP_CNT  = CNT_W'(CAPACITY);
  localparam ptr_t           LAST_PTR = PTR_W'(CAPACITY - 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // position a steps right of p, a no larger than the capacity
  function automatic ptr_t ring_add(ptr_t p, cnt_t a);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - PTR_W){1'b0}}, p} + {1'b0, a};
    if (s >= CAP_EXT) begin
      s = s - CAP_EXT;
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_dec(ptr_t p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dqr_ram.sv @@
// ----------------------------------------------------------------------------
// dqr_ram
// generic ram, one write port and two registered read ports, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module dqr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

@@ rtl/bounded_deque_with_reverse.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse
// bounded double-ended queue of words with a one-step reverse
// ----------------------------------------------------------------------------
// One word in gives one word out. A word is taken every cycle when the output
// is drained, and its result word passes the input register, then the result
// register. The accepted word waits in the input register while the new
// pointer, count and direction flag are worked out. At the edge that takes the
// step they take effect, the ring store is written, and the new front and back
// slots are read into the registered read ports. A slot written at that same
// edge comes from a bypass. A stalled output holds its result plus one more word
// in the input register, and then the input stalls too. A push on a full store
// or a pop on an empty one leaves the state alone and is reported in status. The
// ring store has no reset; only live slots are ever shown.
`default_nettype none

module bounded_deque_with_reverse
  import dqr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // func, push_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // front_value, back_value, item_count,
                                            // is_empty, status
);

  // input register
  logic    in_vld_r;
  func_t   in_func_r;
  word_t   in_val_r;

  // deque state
  ptr_t    head_r, head_nxt;
  cnt_t    cnt_r, cnt_nxt;
  logic    rev_r, rev_nxt;

  // result register
  logic    out_vld_r;
  cnt_t    out_cnt_r;
  logic    out_rev_r;
  status_t out_status_r;
  logic    out_lhit_r;
  logic    out_rhit_r;
  word_t   out_wval_r;

  logic    advance;
  logic    step;
  status_t status_nxt;
  logic    we;
  ptr_t    waddr;
  ptr_t    laddr;
  ptr_t    raddr;
  logic    lhit;
  logic    rhit;
  logic    full;
  logic    empty;
  word_t   ram_l;
  word_t   ram_r;
  word_t   left_val;
  word_t   right_val;
  word_t   front_val;
  word_t   back_val;
  logic    out_empty;

  assign advance   = !out_vld_r || out_tready;
  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= func_t'(in_tdata[IN_FUNC_LSB +: FUNC_W]);
      in_val_r  <= in_tdata[IN_VALUE_LSB +: WORD_WIDTH];
    end
  end

  assign full  = (cnt_r == CAP_CNT);
  assign empty = (cnt_r == '0);

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    status_nxt = ST_DONE;
    we         = 1'b0;
    waddr      = head_r;
    unique case (in_func_r)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          we      = step;
          cnt_nxt = cnt_r + 1'b1;
          if ((in_func_r == OP_PUSH_FRONT) ^ rev_r) begin
            head_nxt = ring_dec(head_r);
            waddr    = head_nxt;
          end else begin
            waddr = ring_add(head_r, cnt_r);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          if ((in_func_r == OP_POP_FRONT) ^ rev_r) begin
            head_nxt = ring_add(head_r, CNT_W'(1));
          end
        end
      end
      OP_REVERSE: begin
        if (!empty) begin
          rev_nxt = !rev_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign laddr = head_nxt;
  assign raddr = ring_add(head_nxt, (cnt_nxt == '0) ? '0 : cnt_nxt - 1'b1);
  // read-first store, so a slot written this cycle comes from the bypass
  assign lhit  = we && (waddr == laddr);
  assign rhit  = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      cnt_r     <= '0;
      rev_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        head_r <= head_nxt;
        cnt_r  <= cnt_nxt;
        rev_r  <= rev_nxt;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_cnt_r    <= cnt_nxt;
      out_rev_r    <= rev_nxt;
      out_status_r <= status_nxt;
      out_lhit_r   <= lhit;
      out_rhit_r   <= rhit;
      out_wval_r   <= in_val_r;
    end
  end

  dqr_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_val_r),
    .re      (step),
    .raddr_a (laddr),
    .raddr_b (raddr),
    .rdata_a (ram_l),
    .rdata_b (ram_r)
  );

  assign left_val  = out_lhit_r ? out_wval_r : ram_l;
  assign right_val = out_rhit_r ? out_wval_r : ram_r;
  assign out_empty = (out_cnt_r == '0);
  assign front_val = out_empty ? '0 : (out_rev_r ? right_val : left_val);
  assign back_val  = out_empty ? '0 : (out_rev_r ? left_val : right_val);

  assign out_tvalid = out_vld_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_FRONT_LSB +: WORD_WIDTH] = front_val;
    out_tdata[OUT_BACK_LSB +: WORD_WIDTH]  = back_val;
    out_tdata[OUT_COUNT_LSB +: CNT_W]      = out_cnt_r;
    out_tdata[OUT_EMPTY_LSB]               = out_empty;
    out_tdata[OUT_STATUS_LSB +: STATUS_W]  = out_status_r;
  end

endmodule

`default_nettype wire

@@ rtl/dqr_checker.sv @@
// ----------------------------------------------------------------------------
// dqr_checker
// port-level checks for the bounded deque with reverse
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dqr_checker
  import dqr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  cnt_t    cnt;
  logic    is_empty;
  status_t status;
  word_t   front;
  word_t   back;

  assign cnt      = out_tdata[OUT_COUNT_LSB +: CNT_W];
  assign is_empty = out_tdata[OUT_EMPTY_LSB];
  assign status   = status_t'(out_tdata[OUT_STATUS_LSB +: STATUS_W]);
  assign front    = out_tdata[OUT_FRONT_LSB +: WORD_WIDTH];
  assign back     = out_tdata[OUT_BACK_LSB +: WORD_WIDTH];

  `DQR_ASSERT_RST(a_no_word_after_reset, clk, !rst_n |=> !out_tvalid, "result word after reset")

  `DQR_ASSERT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  `DQR_ASSERT(a_count_bound, clk, rst_n, out_tvalid |-> cnt <= CAP_CNT, "count above capacity")

  `DQR_ASSERT(a_empty_view, clk, rst_n, out_tvalid |-> (is_empty == (cnt == '0)) && (!is_empty || (front == '0 && back == '0)), "empty flag or values inconsistent")

  `DQR_ASSERT(a_status_count, clk, rst_n, out_tvalid |-> (status != ST_PUSH_FULL || cnt == CAP_CNT) && (status != ST_POP_EMPTY || cnt == '0), "status disagrees with count")

endmodule

bind bounded_deque_with_reverse dqr_checker u_dqr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ bench/deque_checker.sv @@
// ----------------------------------------------------------------------------
// deque_checker
// watches both streams of the bounded deque with reverse, keeps its own
// ring, head, count and direction flag, and checks every result word field
// by field against the front, back, count, empty flag and status it expects
// ----------------------------------------------------------------------------
module deque_checker
  import dqr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // func, push_value
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // front_value, back_value, item_count,
                                            // is_empty, status
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct {
    word_t   front;
    word_t   back;
    cnt_t    count;
    logic    empty;
    status_t status;
  } deque_view_t;

  word_t       ring_copy [CAPACITY];
  int          left_end;
  int          live_words;
  bit          flipped;
  deque_view_t views_due [$];
  deque_view_t oldest_view;
  deque_view_t next_view;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    left_end    = 0;
    live_words  = 0;
    flipped     = 1'b0;
  end

  // apply one operation to the local copy and return the view after it
  task automatic apply_op(input logic [FUNC_W-1:0] code, input word_t value,
                          output deque_view_t view);
    bit      to_left;
    status_t st;
    word_t   left_word;
    word_t   right_word;
    st = ST_DONE;
    case (code)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (live_words >= CAPACITY) begin
          st = ST_PUSH_FULL;
        end else begin
          to_left = (code == OP_PUSH_FRONT) != flipped;
          if (to_left) begin
            left_end = (left_end + CAPACITY - 1) % CAPACITY;
            ring_copy[left_end] = value;
          end else begin
            ring_copy[(left_end + live_words) % CAPACITY] = value;
          end
          live_words++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (live_words == 0) begin
          st = ST_POP_EMPTY;
        end else begin
          to_left = (code == OP_POP_FRONT) != flipped;
          if (to_left) begin
            left_end = (left_end + 1) % CAPACITY;
          end
          live_words--;
        end
      end
      OP_REVERSE: begin
        if (live_words != 0) begin
          flipped = !flipped;
        end
      end
      default: begin
      end
    endcase
    view.count  = cnt_t'(live_words);
    view.status = st;
    if (live_words == 0) begin
      view.front = '0;
      view.back  = '0;
      view.empty = 1'b1;
    end else begin
      left_word  = ring_copy[left_end];
      right_word = ring_copy[(left_end + live_words - 1) % CAPACITY];
      view.front = flipped ? right_word : left_word;
      view.back  = flipped ? left_word : right_word;
      view.empty = 1'b0;
    end
  endtask

  task automatic check_field(input string field, input logic [WORD_WIDTH-1:0] want_v,
                             input logic [WORD_WIDTH-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      left_end   = 0;
      live_words = 0;
      flipped    = 1'b0;
      views_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (views_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, out_tdata);
        end else begin
          oldest_view = views_due.pop_front();
          check_field("front_value", oldest_view.front,
                      out_tdata[OUT_FRONT_LSB +: WORD_WIDTH]);
          check_field("back_value", oldest_view.back,
                      out_tdata[OUT_BACK_LSB +: WORD_WIDTH]);
          check_field("item_count", WORD_WIDTH'(oldest_view.count),
                      WORD_WIDTH'(out_tdata[OUT_COUNT_LSB +: CNT_W]));
          check_field("is_empty", WORD_WIDTH'(oldest_view.empty),
                      WORD_WIDTH'(out_tdata[OUT_EMPTY_LSB]));
          check_field("status", WORD_WIDTH'(oldest_view.status),
                      WORD_WIDTH'(out_tdata[OUT_STATUS_LSB +: STATUS_W]));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_op(in_tdata[IN_FUNC_LSB +: FUNC_W], in_tdata[IN_VALUE_LSB +: WORD_WIDTH],
                 next_view);
        views_due.push_back(next_view);
      end
    end
    outstanding = views_due.size();
  end

endmodule

@@ bench/tb_bounded_deque_with_reverse.sv @@
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_reverse
// drives pushes, pops, reverses and spare codes into the deque: a short
// directed run over empty, full and reversed cases, then random bursts that lean
// toward filling, draining or neither, under changing idle rates on both streams
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_reverse;
  import dqr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [FUNC_W-1:0] OP_SPARE_FIRST = FUNC_W'(OP_REVERSE) + 1'b1;
  localparam logic [FUNC_W-1:0] OP_SPARE_LAST  = '1;

  typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // func, push_value
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // front_value, back_value, item_count,
                                     // is_empty, status
  int mismatches;
  int outstanding;
  int cycles        = 0;
  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  bounded_deque_with_reverse dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  deque_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver side, with a long hold-off whenever one is asked for
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [FUNC_W-1:0] code, input word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - FUNC_W - WORD_WIDTH){1'b0}}, value, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(15);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input lean_t lean);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(99);
    push_pct = (lean == LEAN_FILL) ? 60 : (lean == LEAN_DRAIN) ? 15 : 40;
    pop_pct  = (lean == LEAN_FILL) ? 15 : (lean == LEAN_DRAIN) ? 60 : 40;
    if (r < push_pct) begin
      return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else if (r < push_pct + pop_pct) begin
      return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    end else if (r < 95) begin
      return OP_REVERSE;
    end
    return FUNC_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  task automatic send_random(input int n_words);
    lean_t lean;
    int    burst_left;
    burst_left = 0;
    lean = LEAN_EVEN;
    for (int i = 0; i < n_words; i++) begin
      if (burst_left == 0) begin
        lean = lean_t'($urandom_range(2));
        burst_left = $urandom_range(24, 4);
      end
      burst_left--;
      send_word(pick_op(lean), pick_value());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty deque, spare codes
    send_word(OP_POP_FRONT, '1);
    send_word(OP_POP_BACK, '0);
    send_word(OP_REVERSE, '1);
    send_word(OP_SPARE_FIRST, '1);
    send_word(OP_SPARE_LAST, '0);
    // fill from both ends
    for (int k = 0; k < CAPACITY; k++) begin
      send_word(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                (k == 0) ? '1 : (k == 1) ? '0 : (k == 2) ? {32{2'b10}} :
                (k == 3) ? {32{2'b01}} : {$urandom, $urandom});
    end
    // full deque, then reversed
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_PUSH_BACK, '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    wait_drained();

    send_idle_pct = 24;
    sink_idle_pct = 84;
    send_random(540);
    wait_drained();

    send_idle_pct = 84;
    sink_idle_pct = 24;
    send_random(270);
    wait_drained();
    send_random(270);
    wait_drained();

    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_asks++;
    send_random(540);
    wait_drained();

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dqr_pkg.sv
rtl/dqr_ram.sv
rtl/bounded_deque_with_reverse.sv
rtl/dqr_checker.sv
bench/deque_checker.sv
bench/tb_bounded_deque_with_reverse.sv
